// File: src/smlb_pkg.sv
// Shared types and constants for the stepper move block with limit back-off.
package smlb_pkg;

  // Limit on requested step count.
  localparam int unsigned MaxSteps = 255;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP_MODE       = 2'd0;
  localparam logic [1:0] REG_BACKOFF_STEPS   = 2'd1;
  localparam logic [1:0] REG_RELEASE_SAMPLES = 2'd2;

  // Register reset values.
  localparam logic [1:0] StepModeRst       = 2'd0;
  localparam logic [7:0] BackoffStepsRst   = 8'd99;
  localparam logic [3:0] ReleaseSamplesRst = 4'd10;

  // Action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;

  // Direction codes.
  localparam logic [1:0] DIR_CW  = 2'd1;
  localparam logic [1:0] DIR_CCW = 2'd2;

  // Step mode codes that drive the microstep pins.
  localparam logic [1:0] MODE_HALF    = 2'd1;
  localparam logic [1:0] MODE_QUARTER = 2'd2;

  // Phase codes; the fourth code behaves as idle.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MOVE = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_CW_DONE  = 3'd0;
  localparam logic [2:0] ST_CCW_DONE = 3'd1;
  localparam logic [2:0] ST_CW_REL   = 3'd2;
  localparam logic [2:0] ST_CCW_REL  = 3'd3;
  localparam logic [2:0] ST_FAIL     = 3'd4;
  localparam logic [2:0] ST_BADDIR   = 3'd5;

  typedef struct packed {
    logic [1:0] step_mode;
    logic [7:0] backoff_steps;
    logic [3:0] release_samples;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [1:0] direction;
    logic [7:0] step_count;
    logic       limit_level;
  } item_t;

  typedef struct packed {
    logic       step_pulse;
    logic       dir_level;
    logic       awake;
    logic       ms1;
    logic       ms2;
    logic       limit_lamp;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] steps_taken;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       moving_ccw;
    logic       first_dir_cw;
    logic [7:0] pulses_left;
    logic [7:0] pulses_done;
    logic [3:0] release_left;
    logic       lamp;
  } state_t;

endpackage

// File: src/smlb_if.sv
// Valid/ready channel interfaces for move items and results.
interface smlb_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] direction;
  logic [7:0] step_count;
  logic       limit_level;

  modport source (output valid, action, direction, step_count, limit_level, input ready);
  modport sink   (input valid, action, direction, step_count, limit_level, output ready);
endinterface

interface smlb_res_if;
  logic       valid;
  logic       ready;
  logic       step_pulse;
  logic       dir_level;
  logic       awake;
  logic       ms1;
  logic       ms2;
  logic       limit_lamp;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] steps_taken;

  modport source (output valid, step_pulse, dir_level, awake, ms1, ms2, limit_lamp,
                  done_res, status, steps_taken, input ready);
  modport sink   (input valid, step_pulse, dir_level, awake, ms1, ms2, limit_lamp,
                  done_res, status, steps_taken, output ready);
endinterface

// File: src/smlb_step.sv
// Next-state and result logic for one item.
module smlb_step (
  input  smlb_pkg::cfg_t   cfg_i,
  input  smlb_pkg::state_t state_i,
  input  smlb_pkg::item_t  item_i,
  output smlb_pkg::state_t state_o,
  output smlb_pkg::res_t   res_o
);
  import smlb_pkg::*;

  logic [7:0]      cnt;
  logic [7:0]      left_dec;
  logic [7:0]      done_inc;
  logic [3:0]      rel_dec;
  logic            rel_hit;
  logic            released;
  logic [1:0]      ph;

  always_comb begin
    // compare at full width so any step limit clamps correctly
    if (32'(item_i.step_count) > MaxSteps) begin
      cnt = MaxSteps[7:0];
    end else begin
      cnt = item_i.step_count;
    end
    left_dec = state_i.pulses_left - 8'd1;
    done_inc = state_i.pulses_done + 8'd1;
    rel_dec  = state_i.release_left - 4'd1;
    rel_hit  = !item_i.limit_level && (state_i.release_left != 4'd0);
    released = rel_hit && (rel_dec == 4'd0);
    ph       = (state_i.phase == PH_MOVE || state_i.phase == PH_BACK) ? state_i.phase : PH_IDLE;

    state_o       = state_i;
    state_o.phase = ph;
    res_o         = '0;

    if (item_i.action == ACT_MOVE) begin
      if (ph == PH_IDLE) begin
        if (item_i.direction != DIR_CW && item_i.direction != DIR_CCW) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_BADDIR;
        end else begin
          state_o.first_dir_cw = (item_i.direction == DIR_CW);
          state_o.moving_ccw   = (item_i.direction != DIR_CW);
          state_o.pulses_done  = 8'd0;
          state_o.pulses_left  = cnt;
          if (cnt == 8'd0) begin
            res_o.done_res = 1'b1;
            res_o.status   = (item_i.direction == DIR_CW) ? ST_CW_DONE : ST_CCW_DONE;
          end else begin
            state_o.phase   = PH_MOVE;
            res_o.dir_level = (item_i.direction != DIR_CW);
            res_o.awake     = 1'b1;
            res_o.ms1       = (cfg_i.step_mode == MODE_HALF);
            res_o.ms2       = (cfg_i.step_mode == MODE_QUARTER);
          end
        end
      end
    end else if (ph == PH_MOVE) begin
      res_o.step_pulse = 1'b1;
      res_o.dir_level  = state_i.moving_ccw;
      res_o.awake      = 1'b1;
      res_o.ms1        = (cfg_i.step_mode == MODE_HALF);
      res_o.ms2        = (cfg_i.step_mode == MODE_QUARTER);
      if (item_i.limit_level) begin
        // limit hit: reverse and start backing off
        state_o.lamp         = 1'b1;
        state_o.moving_ccw   = !state_i.moving_ccw;
        state_o.pulses_left  = cfg_i.backoff_steps;
        state_o.pulses_done  = 8'd0;
        state_o.release_left = cfg_i.release_samples;
        if (cfg_i.backoff_steps == 8'd0) begin
          state_o.phase  = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.status   = ST_FAIL;
        end else begin
          state_o.phase = PH_BACK;
        end
      end else begin
        state_o.pulses_done = done_inc;
        state_o.pulses_left = left_dec;
        if (left_dec == 8'd0) begin
          state_o.phase     = PH_IDLE;
          res_o.done_res    = 1'b1;
          res_o.status      = state_i.first_dir_cw ? ST_CW_DONE : ST_CCW_DONE;
          res_o.steps_taken = done_inc;
        end
      end
    end else if (ph == PH_BACK) begin
      res_o.step_pulse = 1'b1;
      res_o.dir_level  = state_i.moving_ccw;
      res_o.awake      = 1'b1;
      res_o.ms1        = (cfg_i.step_mode == MODE_HALF);
      res_o.ms2        = (cfg_i.step_mode == MODE_QUARTER);
      if (rel_hit) begin
        state_o.release_left = rel_dec;
      end
      if (released) begin
        state_o.lamp      = 1'b0;
        state_o.phase     = PH_IDLE;
        res_o.done_res    = 1'b1;
        res_o.status      = state_i.first_dir_cw ? ST_CW_REL : ST_CCW_REL;
        res_o.steps_taken = state_i.pulses_done;
      end else begin
        state_o.pulses_done = done_inc;
        state_o.pulses_left = left_dec;
        if (left_dec == 8'd0) begin
          state_o.phase     = PH_IDLE;
          res_o.done_res    = 1'b1;
          res_o.status      = ST_FAIL;
          res_o.steps_taken = done_inc;
        end
      end
    end

    res_o.limit_lamp = state_o.lamp;
  end

endmodule

// File: src/stepper_move_with_limit_backoff.sv
// Top level of the stepper move block with limit-switch back-off.
// Takes move commands and step ticks on item_in and returns one result per
// item on res_out. An item transfers into an input register; from there
// the step logic updates the move state and the result lands in an output
// register. Throughput is one item per cycle while the sink keeps res_out
// ready: the move state (phase, pulse counters, release counter, lamp) is
// updated once per item. Both stages stall together only when a result
// waits at the output and the sink is not ready. Configuration writes on
// cfg_we_i take effect at the next edge and should be made while idle.
module stepper_move_with_limit_backoff (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  smlb_item_if.sink             item_in,
  smlb_res_if.source            res_out
);
  import smlb_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  item_t  item_q;
  logic   item_vld_q;
  res_t   res_q, res_d;
  logic   res_vld_q;
  logic   advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_mode       <= StepModeRst;
      cfg_q.backoff_steps   <= BackoffStepsRst;
      cfg_q.release_samples <= ReleaseSamplesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_MODE:       cfg_q.step_mode       <= cfg_data_i[1:0];
        REG_BACKOFF_STEPS:   cfg_q.backoff_steps   <= cfg_data_i;
        REG_RELEASE_SAMPLES: cfg_q.release_samples <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // stage advances when an item waits and the output slot frees up
  assign advance       = item_vld_q && (!res_vld_q || res_out.ready);
  assign item_in.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_in.ready) begin
      item_vld_q <= item_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      item_q.action      <= item_in.action;
      item_q.direction   <= item_in.direction;
      item_q.step_count  <= item_in.step_count;
      item_q.limit_level <= item_in.limit_level;
    end
  end

  smlb_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_out.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_out.valid       = res_vld_q;
  assign res_out.step_pulse  = res_q.step_pulse;
  assign res_out.dir_level   = res_q.dir_level;
  assign res_out.awake       = res_q.awake;
  assign res_out.ms1         = res_q.ms1;
  assign res_out.ms2         = res_q.ms2;
  assign res_out.limit_lamp  = res_q.limit_lamp;
  assign res_out.done_res    = res_q.done_res;
  assign res_out.status      = res_q.status;
  assign res_out.steps_taken = res_q.steps_taken;

endmodule
